// ===== sv/assert_macros.svh =====
// Assertion macros shared by the decoder modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// Check that a condition implies another in the same cycle
`define ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Check that a condition implies another in the next cycle
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/u8sd_pkg.sv =====
// Shared types, constants and functions of the UTF-8 stream decoder
package u8sd_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned CpW        = 21;
  localparam int unsigned CountW     = 3;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_CONT = 2'd1,
    ST_TRUNC    = 2'd2
  } status_e;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [CountW-1:0] byte_count;
    status_e           status;
    logic              right_to_left;
    logic              run_last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    res_a;
    result_t    res_b;
  } push_t;

  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    if (b[7] == 1'b0) begin
      len = 3'd1;
    end else if ((b & 8'hE0) == 8'hC0) begin
      len = 3'd2;
    end else if ((b & 8'hF0) == 8'hE0) begin
      len = 3'd3;
    end else if ((b & 8'hF8) == 8'hF0) begin
      len = 3'd4;
    end else begin
      len = 3'd1;
    end
    return len;
  endfunction

  function automatic logic in_rtl_range(input logic [CpW-1:0] cp);
    return cp inside {[21'h000590 : 21'h0005FF], [21'h000600 : 21'h0006FF],
                      [21'h000750 : 21'h00077F], [21'h0008A0 : 21'h0008FF]};
  endfunction

  function automatic result_t make_result(input logic [CpW-1:0] cp,
                                          input logic [CountW-1:0] count,
                                          input status_e st);
    result_t r;
    r.code_point    = (st == ST_OK) ? cp : '0;
    r.byte_count    = count;
    r.status        = st;
    r.right_to_left = (st == ST_OK) ? in_rtl_range(cp) : 1'b0;
    r.run_last      = 1'b0;
    return r;
  endfunction

endpackage

// ===== sv/utf8_stream_decoder_rtl_core.sv =====
// Top level of the UTF-8 stream decoder
//
// Takes one UTF-8 byte per beat and gives decoded codepoints with byte count,
// status and a right-to-left flag; tlast on a result marks the last result of
// its input byte. A byte is accepted every cycle while the result queue has
// room for two results. Most bytes give at most one result; a bad
// continuation byte can give two, and the single result port then moves one
// result per cycle while the output is not stalled, so sustained input rate is
// one byte per cycle as long as results average no more than one per byte. A
// result is held in the queue (QDEPTH entries, default 4) and then in the
// output register before it appears on the output.
module utf8_stream_decoder_rtl_core #(
  parameter int unsigned QDEPTH = u8sd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // in_byte[7:0]
  input  logic        s_axis_tlast_i,   // end_of_buffer
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // code_point[20:0], byte_count[23:21]
  output logic [2:0]  m_axis_tuser_o,   // status[1:0], right_to_left[2]
  output logic        m_axis_tlast_o    // run_last
);

  u8sd_pkg::push_t   push;
  logic              space_ok;
  logic              pop;
  logic              head_valid;
  u8sd_pkg::result_t head;
  u8sd_pkg::result_t out_res;

  u8sd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_byte_i  (s_axis_tdata_i),
    .in_eob_i   (s_axis_tlast_i),
    .space_ok_i (space_ok),
    .in_ready_o (s_axis_tready_o),
    .push_o     (push)
  );

  u8sd_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_ok_o   (space_ok),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  u8sd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_o        (out_res)
  );

  assign m_axis_tdata_o = {out_res.byte_count, out_res.code_point};
  assign m_axis_tuser_o = {out_res.right_to_left, out_res.status};
  assign m_axis_tlast_o = out_res.run_last;

endmodule

// ===== sv/u8sd_front.sv =====
// Front end: accept bytes, track the open sequence and build result beats
`include "assert_macros.svh"

module u8sd_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [7:0]      in_byte_i,
  input  logic            in_eob_i,
  input  logic            space_ok_i,
  output logic            in_ready_o,
  output u8sd_pkg::push_t push_o
);

  logic [1:0]                pending_q, pending_d;
  logic [2:0]                seqlen_q, seqlen_d;
  logic [u8sd_pkg::CpW-1:0]  acc_q, acc_d;

  logic                      accept;
  logic [2:0]                lead_len;
  logic [u8sd_pkg::CpW-1:0]  lead_acc;
  logic                      lead_emit;
  u8sd_pkg::result_t         lead_res;
  logic [2:0]                received;
  logic [u8sd_pkg::CpW-1:0]  acc_shift;
  logic [1:0]                pend_dec;
  logic                      is_cont;
  logic [1:0]                n;
  u8sd_pkg::result_t         res_a, res_b;

  assign in_ready_o = space_ok_i;
  assign accept     = in_valid_i && space_ok_i;

  always_comb begin
    lead_len  = u8sd_pkg::lead_length(in_byte_i);
    case (lead_len)
      3'd2:    lead_acc = {16'd0, in_byte_i[4:0]};
      3'd3:    lead_acc = {17'd0, in_byte_i[3:0]};
      default: lead_acc = {18'd0, in_byte_i[2:0]};
    endcase
    lead_emit = (lead_len == 3'd1) || in_eob_i;
    lead_res  = (lead_len == 3'd1)
              ? u8sd_pkg::make_result({13'd0, in_byte_i}, 3'd1, u8sd_pkg::ST_OK)
              : u8sd_pkg::make_result('0, 3'd1, u8sd_pkg::ST_TRUNC);
    received  = seqlen_q - {1'b0, pending_q};
    acc_shift = {acc_q[14:0], in_byte_i[5:0]};
    pend_dec  = pending_q - 2'd1;
    is_cont   = (in_byte_i[7:6] == 2'b10);

    res_a     = lead_res;
    res_b     = lead_res;
    n         = 2'd0;
    pending_d = '0;
    seqlen_d  = '0;
    acc_d     = '0;

    if (pending_q != 2'd0 && is_cont) begin
      if (pend_dec == 2'd0) begin
        res_a = u8sd_pkg::make_result(acc_shift, seqlen_q, u8sd_pkg::ST_OK);
        n     = 2'd1;
      end else if (in_eob_i) begin
        res_a = u8sd_pkg::make_result('0, received + 3'd1, u8sd_pkg::ST_TRUNC);
        n     = 2'd1;
      end else begin
        pending_d = pend_dec;
        seqlen_d  = seqlen_q;
        acc_d     = acc_shift;
      end
    end else begin
      if (pending_q != 2'd0) begin
        res_a = u8sd_pkg::make_result('0, received, u8sd_pkg::ST_BAD_CONT);
        n     = lead_emit ? 2'd2 : 2'd1;
      end else begin
        n     = lead_emit ? 2'd1 : 2'd0;
      end
      if (!lead_emit) begin
        pending_d = lead_len[1:0] - 2'd1;
        seqlen_d  = lead_len;
        acc_d     = lead_acc;
      end
    end

    if (n == 2'd1) begin
      res_a.run_last = 1'b1;
    end
    if (n == 2'd2) begin
      res_b.run_last = 1'b1;
    end

    push_o.count = accept ? n : 2'd0;
    push_o.res_a = res_a;
    push_o.res_b = res_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
      seqlen_q  <= '0;
      acc_q     <= '0;
    end else if (accept) begin
      pending_q <= pending_d;
      seqlen_q  <= seqlen_d;
      acc_q     <= acc_d;
    end
  end

  `ASSERT_NEXT(a_eob_closes, accept && in_eob_i, pending_q == 2'd0)
  `ASSERT_IMPLIES(a_two_after_bad, push_o.count == 2'd2,
                  push_o.res_a.status == u8sd_pkg::ST_BAD_CONT)

endmodule

// ===== sv/u8sd_queue.sv =====
// Result queue between front and back end: up to two pushes, one pop per cycle
`include "assert_macros.svh"

module u8sd_queue #(
  parameter int unsigned QDEPTH = u8sd_pkg::QueueDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  u8sd_pkg::push_t   push_i,
  output logic              space_ok_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output u8sd_pkg::result_t head_o
);

  localparam int unsigned AW = (QDEPTH > 2) ? $clog2(QDEPTH) : 1;
  localparam int unsigned CW = $clog2(QDEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QDEPTH - 1);
  localparam logic [CW-1:0] SpaceMax = CW'(QDEPTH - 2);
  localparam logic [CW-1:0] DepthC = CW'(QDEPTH);

  u8sd_pkg::result_t mem_q [QDEPTH];
  logic [AW-1:0]     wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     wr_next, wr_next2;
  logic              do_pop;

  assign wr_next      = (wr_ptr_q == LastIdx) ? '0 : wr_ptr_q + AW'(1);
  assign wr_next2     = (wr_next == LastIdx) ? '0 : wr_next + AW'(1);
  assign head_valid_o = (count_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign space_ok_o   = (count_q <= SpaceMax);
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    case (push_i.count)
      2'd1:    wr_ptr_d = wr_next;
      2'd2:    wr_ptr_d = wr_next2;
      default: wr_ptr_d = wr_ptr_q;
    endcase
    rd_ptr_d = do_pop ? ((rd_ptr_q == LastIdx) ? '0 : rd_ptr_q + AW'(1)) : rd_ptr_q;
    count_d  = count_q + CW'(push_i.count) - CW'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_next] <= push_i.res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  `ASSERT_ALWAYS(a_count_bound, count_q <= DepthC)
  `ASSERT_IMPLIES(a_push_fits, push_i.count != 2'd0, count_q <= SpaceMax)

endmodule

// ===== sv/u8sd_back.sv =====
// Back end: output register that drives the result stream
`include "assert_macros.svh"

module u8sd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  u8sd_pkg::result_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output u8sd_pkg::result_t out_o
);

  logic              valid_q, valid_d;
  u8sd_pkg::result_t out_q;

  assign pop_o       = head_valid_i && (!valid_q || out_ready_i);
  assign out_valid_o = valid_q;
  assign out_o       = out_q;

  always_comb begin
    if (pop_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  `ASSERT_NEXT(a_pop_loads, pop_o, valid_q)

endmodule

// ===== verif/utf8_stream_decoder_rtl_core_test.sv =====
// Self-checking stream testbench for the UTF-8 stream decoder core
`timescale 1ns / 1ps

module utf8_stream_decoder_rtl_core_test;

  localparam int RANDOM_BYTES = 500;
  localparam int CALM_TAIL    = 60;
  localparam int STUCK_LIMIT  = 1000;

  // bit 8 marks the end of a buffer
  localparam logic [8:0] DIRECTED [24] = '{
    9'h000, 9'h07F,
    9'h0D7, 9'h090,
    9'h0E0, 9'h0A2, 9'h0A0,
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,
    9'h080, 9'h0FF,
    9'h0C3, 9'h041,
    9'h0E2, 9'h082, 9'h0C3, 9'h0A9,
    9'h0E2, 9'h182,
    9'h0F0, 9'h1C3,
    9'h141
  };

  typedef struct {
    logic [7:0] data;
    logic       last;
    logic       drain_first;
  } byte_beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic [7:0]  s_data = '0;
  logic        s_last = 1'b0;
  logic        m_ready = 1'b0;
  logic        s_axis_tready_o;
  logic        m_axis_tvalid_o;
  logic [23:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  byte_beat_t          byte_queue[$];
  u8sd_pkg::result_t   due_results[$];
  u8sd_pkg::result_t   step_results[$];

  logic [1:0]  cont_left = '0;
  logic [2:0]  seq_len = '0;
  logic [20:0] cp_acc = '0;

  logic        calm_tail = 1'b0;
  int          send_gap = 0;
  int          recv_stall = 0;
  int          stuck_cycles = 0;
  int          mismatches = 0;
  int          bytes_sent = 0;
  int          results_seen = 0;
  int          n_bad = 0;
  int          n_trunc = 0;
  int          n_rtl = 0;

  utf8_stream_decoder_rtl_core uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic note_result(input logic [20:0] cp, input logic [2:0] count,
                             input u8sd_pkg::status_e st);
    u8sd_pkg::result_t r;
    logic              rtl;
    rtl = (cp >= 21'h000590 && cp <= 21'h0006FF) ||
          (cp >= 21'h000750 && cp <= 21'h00077F) ||
          (cp >= 21'h0008A0 && cp <= 21'h0008FF);
    r.code_point    = (st == u8sd_pkg::ST_OK) ? cp : '0;
    r.byte_count    = count;
    r.status        = st;
    r.right_to_left = (st == u8sd_pkg::ST_OK) && rtl;
    r.run_last      = 1'b0;
    step_results.push_back(r);
    if (st == u8sd_pkg::ST_BAD_CONT) n_bad++;
    if (st == u8sd_pkg::ST_TRUNC) n_trunc++;
    if (r.right_to_left) n_rtl++;
  endtask

  task automatic open_sequence(input logic [7:0] b, input logic eob);
    logic [2:0] len;
    casez (b)
      8'b110?????: begin
        len    = 3'd2;
        cp_acc = {16'd0, b[4:0]};
      end
      8'b1110????: begin
        len    = 3'd3;
        cp_acc = {17'd0, b[3:0]};
      end
      8'b11110???: begin
        len    = 3'd4;
        cp_acc = {18'd0, b[2:0]};
      end
      default: len = 3'd1;
    endcase
    if (len == 3'd1) begin
      note_result({13'd0, b}, 3'd1, u8sd_pkg::ST_OK);
    end else if (eob) begin
      note_result('0, 3'd1, u8sd_pkg::ST_TRUNC);
      cp_acc = '0;
    end else begin
      seq_len   = len;
      cont_left = 2'(len - 3'd1);
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic eob);
    logic [2:0] got;
    if (cont_left != 2'd0) begin
      got = seq_len - {1'b0, cont_left};
      if (b[7:6] == 2'b10) begin
        cp_acc    = {cp_acc[14:0], b[5:0]};
        cont_left = cont_left - 2'd1;
        if (cont_left == 2'd0) begin
          note_result(cp_acc, seq_len, u8sd_pkg::ST_OK);
        end else if (eob) begin
          note_result('0, got + 3'd1, u8sd_pkg::ST_TRUNC);
        end
        if (cont_left == 2'd0 || eob) begin
          cont_left = '0;
          seq_len   = '0;
          cp_acc    = '0;
        end
      end else begin
        note_result('0, got, u8sd_pkg::ST_BAD_CONT);
        cont_left = '0;
        seq_len   = '0;
        cp_acc    = '0;
        open_sequence(b, eob);
      end
    end else begin
      open_sequence(b, eob);
    end
    if (step_results.size() != 0) begin
      step_results[$].run_last = 1'b1;
    end
    while (step_results.size() != 0) due_results.push_back(step_results.pop_front());
  endtask

  task automatic queue_byte(input logic [7:0] b, input logic eob, input logic drain);
    byte_beat_t beat;
    beat.data        = b;
    beat.last        = eob;
    beat.drain_first = drain;
    byte_queue.push_back(beat);
  endtask

  always @(posedge clk_i) begin
    logic offer;
    if (rst_ni) begin
      offer = s_valid;
      if (s_valid && s_axis_tready_o) begin
        decode_byte(s_data, s_last);
        bytes_sent++;
        offer = 1'b0;
      end
      if (!offer) begin
        if (send_gap != 0) begin
          send_gap--;
        end else if (byte_queue.size() != 0 &&
                     !(byte_queue[0].drain_first && due_results.size() != 0)) begin
          if (!calm_tail && $urandom_range(0, 9) == 0) begin
            send_gap = $urandom_range(0, 12);
          end else begin
            s_data <= byte_queue[0].data;
            s_last <= byte_queue[0].last;
            void'(byte_queue.pop_front());
            offer = 1'b1;
          end
        end
      end
      s_valid   <= offer;
      calm_tail <= (byte_queue.size() <= CALM_TAIL);
    end
  end

  always @(posedge clk_i) begin
    u8sd_pkg::result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_ready) begin
        if (due_results.size() == 0) begin
          $error("unexpected result beat: tdata %h tuser %h tlast %b",
                 m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          results_seen++;
          if (m_axis_tdata_o[20:0] !== want.code_point) begin
            $error("code_point: expected %h, got %h", want.code_point, m_axis_tdata_o[20:0]);
            mismatches++;
          end
          if (m_axis_tdata_o[23:21] !== want.byte_count) begin
            $error("byte_count: expected %0d, got %0d", want.byte_count,
                   m_axis_tdata_o[23:21]);
            mismatches++;
          end
          if (m_axis_tuser_o[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o[1:0]);
            mismatches++;
          end
          if (m_axis_tuser_o[2] !== want.right_to_left) begin
            $error("right_to_left: expected %b, got %b", want.right_to_left,
                   m_axis_tuser_o[2]);
            mismatches++;
          end
          if (m_axis_tlast_o !== want.run_last) begin
            $error("run_last: expected %b, got %b", want.run_last, m_axis_tlast_o);
            mismatches++;
          end
        end
      end
      if (recv_stall != 0) begin
        recv_stall--;
        m_ready <= 1'b0;
      end else if (!calm_tail && $urandom_range(0, 9) == 0) begin
        recv_stall = $urandom_range(0, 12);
        m_ready <= 1'b0;
      end else begin
        m_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && m_ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= STUCK_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int          made;
    int          kind;
    int          len;
    int          cut;
    logic        drain;
    logic [7:0]  lead;
    logic [7:0]  cont;
    foreach (DIRECTED[i]) queue_byte(DIRECTED[i][7:0], DIRECTED[i][8], 1'b0);
    made = 0;
    while (made < RANDOM_BYTES) begin
      kind  = $urandom_range(0, 99);
      len   = $urandom_range(1, 4);
      drain = (made == 0) || ($urandom_range(0, 59) == 0);
      if (kind < 12) begin
        // noise
        queue_byte(8'($urandom), $urandom_range(0, 19) == 0, drain);
        made++;
      end else begin
        if (len == 1) begin
          lead = {1'b0, 7'($urandom)};
        end else if (len == 2) begin
          lead = (kind < 30) ? 8'hD6 + 8'($urandom_range(0, 9)) : {3'b110, 5'($urandom)};
        end else if (len == 3) begin
          lead = (kind < 30) ? 8'hE0 : {4'b1110, 4'($urandom)};
        end else begin
          lead = {5'b11110, 3'($urandom)};
        end
        // may be cut short for a broken sequence
        cut = (kind >= 88) ? $urandom_range(0, len - 1) : len - 1;
        queue_byte(lead, $urandom_range(0, 19) == 0, drain);
        for (int i = 0; i < cut; i++) begin
          cont = {2'b10, 6'($urandom)};
          if (i == 0 && len == 3 && kind < 30) cont = 8'hA2 | 8'($urandom_range(0, 1));
          queue_byte(cont, $urandom_range(0, 19) == 0, 1'b0);
        end
        made += 1 + cut;
      end
    end
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (byte_queue.size() != 0 || s_valid) @(posedge clk_i);
    while (due_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    $display("covered %0d bytes and %0d results", bytes_sent, results_seen);
    $display("  %0d bad continuation, %0d truncated, %0d right-to-left",
             n_bad, n_trunc, n_rtl);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
